FILE: rtl/pairwise_diversity_accumulator_assert.svh
// Assertion macros for the pairwise diversity accumulator
`ifndef PAIRWISE_DIVERSITY_ACCUMULATOR_ASSERT_SVH
`define PAIRWISE_DIVERSITY_ACCUMULATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define PDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define PDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/pda_pkg.sv
`timescale 1ns / 1ps
package pda_pkg;
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SELF,
    ST_SELF_WB,
    ST_PAIR_RD,
    ST_PAIR_WB,
    ST_READ,
    ST_CLEAR,
    ST_OUT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture input transaction
    logic clr_ptr;   // restart sweep / column counter
    logic clr_step;  // zero one store entry, advance pointer
    logic self_rd;   // read diagonal entry
    logic pair_rd;   // read buffered sample and pair entry
    logic wb;        // write back accumulated entry
    logic col_inc;   // next earlier sample
    logic rd_req;    // read for host
    logic out_load;  // load output register
    logic pos_adv;   // advance sample position
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    opcode_e op;
    logic    cov_zero;
    logic    cov_gt1;
    logic    col_done;   // column reached current position
    logic    col_last;   // column is the last earlier sample
    logic    clr_done;   // sweep at last entry
    logic    cj_zero;    // buffered sample has no coverage
  } status_t;
endpackage

FILE: rtl/pda_datapath.sv
`timescale 1ns / 1ps
module pda_datapath #(
  parameter int MAX_SAMPLES = 64,
  parameter int SUM_WIDTH   = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pda_pkg::cmd_t         cmd_i,
  output pda_pkg::status_t      sts_o,
  input  logic [6:0]            num_individuals_i,
  input  logic [1:0]            opcode_i,
  input  logic [7:0]            major_count_i,
  input  logic [7:0]            minor_count_i,
  input  logic [5:0]            row_sample_i,
  input  logic [5:0]            col_sample_i,
  output logic [SUM_WIDTH-1:0]  weight_total_o,
  output logic [SUM_WIDTH-1:0]  diversity_total_o,
  output logic                  no_data_o
);
  localparam int SW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int PAIRS = (MAX_SAMPLES * (MAX_SAMPLES + 1)) / 2;
  localparam int PW = $clog2(PAIRS);

  // Stores
  logic [SUM_WIDTH-1:0] wmem [PAIRS];
  logic [SUM_WIDTH-1:0] dmem [PAIRS];
  logic [7:0]           majmem [MAX_SAMPLES];
  logic [7:0]           minmem [MAX_SAMPLES];

  logic [1:0]  op_q;
  logic [7:0]  maj_q, min_q;
  logic [5:0]  row_q, col_q;
  logic [SW-1:0] pos_q, pos_d, cur_q, col_ctr_q;
  logic [PW-1:0] ptr_q, base_q, widx_q;
  logic [8:0]  cov;
  logic [8:0]  cj;
  logic [7:0]  bmaj_q, bmin_q;
  logic [SUM_WIDTH-1:0] wrd_q, drd_q, wadd_q, dadd_q;
  logic        rd_valid_q;
  logic [SW:0] n_use;

  assign cov = {1'b0, maj_q} + {1'b0, min_q};
  assign cj  = {1'b0, bmaj_q} + {1'b0, bmin_q};

  // Effective samples per locus
  always_comb begin
    if (num_individuals_i == 7'd0) n_use = (SW+1)'(1);
    else if ({25'd0, num_individuals_i} > MAX_SAMPLES) n_use = (SW+1)'(MAX_SAMPLES);
    else n_use = (SW+1)'(num_individuals_i);
  end

  // Input capture and current position
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      maj_q <= major_count_i;
      min_q <= minor_count_i;
      if (col_sample_i > row_sample_i) begin
        row_q <= col_sample_i;
        col_q <= row_sample_i;
      end else begin
        row_q <= row_sample_i;
        col_q <= col_sample_i;
      end
      cur_q  <= ({1'b0, pos_q} >= n_use) ? '0 : pos_q;
      base_q <= ({1'b0, pos_q} >= n_use) ? '0 :
                PW'((32'(pos_q) * (32'(pos_q) + 32'd1)) >> 1);
    end
  end

  // Sample position
  always_comb begin
    pos_d = pos_q;
    if (cmd_i.pos_adv) begin
      pos_d = (({1'b0, cur_q} + 1'b1) >= n_use) ? '0 : SW'(cur_q + 1'b1);
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pos_q <= '0;
    else pos_q <= pos_d;
  end

  // Sweep / column counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      col_ctr_q <= '0;
    end else if (cmd_i.clr_ptr) begin
      ptr_q     <= '0;
      col_ctr_q <= '0;
    end else begin
      if (cmd_i.clr_step) ptr_q <= PW'(ptr_q + 1'b1);
      if (cmd_i.col_inc) col_ctr_q <= SW'(col_ctr_q + 1'b1);
    end
  end

  // Locus buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && opcode_i == pda_pkg::OP_ADD) begin
      majmem[({1'b0, pos_q} >= n_use) ? '0 : pos_q] <= major_count_i;
      minmem[({1'b0, pos_q} >= n_use) ? '0 : pos_q] <= minor_count_i;
    end
    if (cmd_i.pair_rd) begin
      bmaj_q <= majmem[col_ctr_q];
      bmin_q <= minmem[col_ctr_q];
    end
  end

  // Increment terms, registered before the add
  always_ff @(posedge clk_i) begin
    if (cmd_i.self_rd) begin
      wadd_q <= SUM_WIDTH'(18'(cov) * 18'(cov - 9'd1));
      dadd_q <= SUM_WIDTH'(17'({maj_q, 1'b0}) * 17'(min_q));
    end else if (cmd_i.wb == 1'b0 && rd_valid_q) begin
      wadd_q <= SUM_WIDTH'(18'(cov) * 18'(cj));
      dadd_q <= SUM_WIDTH'(16'(maj_q) * 16'(bmin_q)) + SUM_WIDTH'(16'(bmaj_q) * 16'(min_q));
    end
  end

  // Pair store: one read port, one write port
  logic [PW-1:0] ridx;
  always_comb begin
    if (cmd_i.rd_req) ridx = PW'((32'(row_q) * (32'(row_q) + 32'd1)) >> 1) + PW'(col_q);
    else if (cmd_i.self_rd) ridx = PW'(base_q + PW'(cur_q));
    else ridx = PW'(base_q + PW'(col_ctr_q));
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      wmem[ptr_q] <= '0;
      dmem[ptr_q] <= '0;
    end else if (cmd_i.wb) begin
      wmem[widx_q] <= wrd_q + wadd_q;
      dmem[widx_q] <= drd_q + dadd_q;
    end
    if (cmd_i.rd_req || cmd_i.self_rd || cmd_i.pair_rd) begin
      wrd_q  <= wmem[ridx];
      drd_q  <= dmem[ridx];
      widx_q <= ridx;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_valid_q <= 1'b0;
    else rd_valid_q <= cmd_i.pair_rd;
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if ({26'd0, row_q} < MAX_SAMPLES) begin
        weight_total_o    <= wrd_q;
        diversity_total_o <= drd_q;
        no_data_o         <= (wrd_q == '0);
      end else begin
        weight_total_o    <= '0;
        diversity_total_o <= '0;
        no_data_o         <= 1'b1;
      end
    end
  end

  assign sts_o.op       = pda_pkg::opcode_e'(op_q);
  assign sts_o.cov_zero = (cov == 9'd0);
  assign sts_o.cov_gt1  = (cov > 9'd1);
  assign sts_o.col_done = (col_ctr_q == cur_q);
  assign sts_o.col_last = (({1'b0, col_ctr_q} + 1'b1) == {1'b0, cur_q});
  assign sts_o.clr_done = (ptr_q == PW'(PAIRS - 1));
  assign sts_o.cj_zero  = (cj == 9'd0);
endmodule

FILE: rtl/pda_ctrl.sv
`timescale 1ns / 1ps
module pda_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  pda_pkg::status_t  sts_i,
  output pda_pkg::cmd_t     cmd_o
);
  pda_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pda_pkg::ST_INIT: if (sts_i.clr_done) state_d = pda_pkg::ST_IDLE;
      pda_pkg::ST_IDLE: if (in_valid_i && !in_stall_o) state_d = pda_pkg::ST_SELF;
      pda_pkg::ST_SELF: begin
        unique case (sts_i.op)
          pda_pkg::OP_ADD:   state_d = sts_i.cov_zero ? pda_pkg::ST_IDLE :
                                       (sts_i.cov_gt1 ? pda_pkg::ST_SELF_WB :
                                        (sts_i.col_done ? pda_pkg::ST_IDLE :
                                         pda_pkg::ST_PAIR_RD));
          pda_pkg::OP_READ:  state_d = pda_pkg::ST_READ;
          pda_pkg::OP_CLEAR: state_d = pda_pkg::ST_CLEAR;
          default:           state_d = pda_pkg::ST_IDLE;
        endcase
      end
      pda_pkg::ST_SELF_WB: state_d = sts_i.col_done ? pda_pkg::ST_IDLE : pda_pkg::ST_PAIR_RD;
      pda_pkg::ST_PAIR_RD: state_d = pda_pkg::ST_OUT;
      pda_pkg::ST_OUT:     state_d = pda_pkg::ST_PAIR_WB;
      pda_pkg::ST_PAIR_WB: state_d = sts_i.col_last ? pda_pkg::ST_IDLE : pda_pkg::ST_PAIR_RD;
      pda_pkg::ST_READ:    if (!out_valid_q || !out_stall_i) state_d = pda_pkg::ST_IDLE;
      pda_pkg::ST_CLEAR:   if (sts_i.clr_done) state_d = pda_pkg::ST_IDLE;
      default:             state_d = pda_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = (state_q != pda_pkg::ST_IDLE);
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      pda_pkg::ST_INIT: cmd_o.clr_step = 1'b1;
      pda_pkg::ST_IDLE: begin
        cmd_o.load    = in_valid_i;
        cmd_o.clr_ptr = 1'b1;
      end
      pda_pkg::ST_SELF: begin
        unique case (sts_i.op)
          pda_pkg::OP_ADD: begin
            cmd_o.pos_adv = 1'b1;
            cmd_o.self_rd = sts_i.cov_gt1;
          end
          pda_pkg::OP_READ: cmd_o.rd_req = 1'b1;
          default: ;
        endcase
      end
      // diagonal entry, column counter stays at the first earlier sample
      pda_pkg::ST_SELF_WB: cmd_o.wb = 1'b1;
      pda_pkg::ST_PAIR_RD: cmd_o.pair_rd = 1'b1;
      pda_pkg::ST_OUT: ;
      pda_pkg::ST_PAIR_WB: begin
        // pair entries skip empty samples
        cmd_o.wb      = !sts_i.cj_zero;
        cmd_o.col_inc = 1'b1;
      end
      pda_pkg::ST_READ: if (!out_valid_q || !out_stall_i) begin
        cmd_o.out_load = 1'b1;
        out_valid_d    = 1'b1;
      end
      pda_pkg::ST_CLEAR: cmd_o.clr_step = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pda_pkg::ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
  assign out_valid_o = out_valid_q;
endmodule

FILE: rtl/pairwise_diversity_accumulator.sv
`timescale 1ns / 1ps
// Add: a self step, plus a diagonal write back when coverage > 1, then for each earlier
//   sample a store read, a multiply and a write back.
// Read: store read, then output register; clear: one entry a cycle over 2080 entries.
// One transaction at a time: in_stall_o is high until the controller is idle again.
// Reset (rst_ni low, async) clears control; a sweep then zeroes all 2080 store entries
// while in_stall_o stays high.
module pairwise_diversity_accumulator #(
  parameter int MAX_SAMPLES = 64,
  parameter int SUM_WIDTH   = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [6:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic [7:0]           major_count_i,
  input  logic [7:0]           minor_count_i,
  input  logic [5:0]           row_sample_i,
  input  logic [5:0]           col_sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SUM_WIDTH-1:0] weight_total_o,
  output logic [SUM_WIDTH-1:0] diversity_total_o,
  output logic                 no_data_o
);
  pda_pkg::cmd_t    cmd;
  pda_pkg::status_t sts;
  logic [6:0] num_q;

  // Sample count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) num_q <= 7'd64;
    else if (cfg_we_i) num_q <= cfg_wdata_i;
  end

  pda_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  pda_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .SUM_WIDTH(SUM_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .num_individuals_i(num_q),
    .opcode_i, .major_count_i, .minor_count_i, .row_sample_i, .col_sample_i,
    .weight_total_o, .diversity_total_o, .no_data_o
  );
endmodule

FILE: rtl/pda_checker.sv
`timescale 1ns / 1ps
`include "pairwise_diversity_accumulator_assert.svh"
module pda_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] opcode_i,
  input logic       no_data_o
);
  // One transaction in flight: accepted input stalls the next cycle
  `PDA_ASSERT_NEXT(busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // Held result stays valid
  `PDA_ASSERT_NEXT(out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  // No result follows directly after an add
  `PDA_ASSERT_NEXT(no_out_add, clk_i, rst_ni,
    in_valid_i && !in_stall_o && opcode_i == pda_pkg::OP_ADD && !out_valid_o, !out_valid_o)
  // Flag is defined whenever a result is offered
  `PDA_ASSERT_IMP(out_known, clk_i, rst_ni, out_valid_o, !$isunknown(no_data_o))
endmodule

bind pairwise_diversity_accumulator pda_checker u_pda_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .opcode_i, .no_data_o
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  localparam int NSAMP = 64;
  localparam int NPAIR = NSAMP * (NSAMP + 1) / 2;
  localparam int RAND_ITEMS = 1950;
  localparam longint CYCLE_LIMIT = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [7:0]  major_count_i = '0;
  logic [7:0]  minor_count_i = '0;
  logic [5:0]  row_sample_i = '0;
  logic [5:0]  col_sample_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] weight_total_o;
  logic [63:0] diversity_total_o;
  logic        no_data_o;

  pairwise_diversity_accumulator u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .opcode_i, .major_count_i, .minor_count_i, .row_sample_i, .col_sample_i,
    .out_valid_o, .out_stall_i, .weight_total_o, .diversity_total_o, .no_data_o
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [63:0] weight;
    logic [63:0] div;
    logic        empty;
  } pair_sums_t;

  // Shadow of the block
  logic [6:0]  samples_cfg;
  int unsigned locus_pos;
  logic [7:0]  buf_maj [NSAMP];
  logic [7:0]  buf_min [NSAMP];
  logic [63:0] weight_sums [NPAIR];
  logic [63:0] div_sums [NPAIR];
  pair_sums_t  pending_reads [$];

  int     mismatches = 0;
  bit     hold_off = 1'b0;
  longint cycles = 0;

  function automatic int tri_idx(int hi, int lo);
    return hi * (hi + 1) / 2 + lo;
  endfunction

  function automatic void clear_sums();
    for (int k = 0; k < NPAIR; k++) begin
      weight_sums[k] = '0;
      div_sums[k] = '0;
    end
  endfunction

  // Apply one accepted transaction to the shadow, queue a read result
  function automatic void predict_sums(pda_pkg::opcode_e op, logic [7:0] maj,
                                       logic [7:0] mnr, logic [5:0] row, logic [5:0] col);
    int unsigned n;
    int unsigned pos;
    int unsigned r;
    int unsigned c;
    logic [63:0] cov;
    logic [63:0] cj;
    pair_sums_t  res;
    n = (samples_cfg == 0) ? 1 : (samples_cfg > NSAMP) ? NSAMP : samples_cfg;
    case (op)
      pda_pkg::OP_ADD: begin
        pos = (locus_pos >= n) ? 0 : locus_pos;
        buf_maj[pos] = maj;
        buf_min[pos] = mnr;
        cov = 64'(maj) + 64'(mnr);
        if (cov > 0) begin
          if (cov > 1) begin
            weight_sums[tri_idx(pos, pos)] += cov * (cov - 1);
            div_sums[tri_idx(pos, pos)] += 64'd2 * 64'(maj) * 64'(mnr);
          end
          for (int j = 0; j < pos; j++) begin
            cj = 64'(buf_maj[j]) + 64'(buf_min[j]);
            if (cj > 0) begin
              weight_sums[tri_idx(pos, j)] += cov * cj;
              div_sums[tri_idx(pos, j)] += 64'(maj) * 64'(buf_min[j])
                                         + 64'(buf_maj[j]) * 64'(mnr);
            end
          end
        end
        pos++;
        locus_pos = (pos >= n) ? 0 : pos;
      end
      pda_pkg::OP_CLEAR: clear_sums();
      pda_pkg::OP_READ: begin
        r = row;
        c = col;
        if (c > r) begin
          r = col;
          c = row;
        end
        res.weight = weight_sums[tri_idx(r, c)];
        res.div = div_sums[tri_idx(r, c)];
        res.empty = (res.weight == 0);
        pending_reads.insert(pending_reads.size(), res);
      end
      default: ;
    endcase
  endfunction

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Check result transactions against the oldest queued read
  pair_sums_t got;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{weight_total_o, diversity_total_o, no_data_o};
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %b", got.weight, got.div,
                                       got.empty);
      end else begin
        if (got !== pending_reads[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp w=%h d=%h nd=%b got w=%h d=%h nd=%b",
                     pending_reads[0].weight, pending_reads[0].div, pending_reads[0].empty,
                     got.weight, got.div, got.empty);
        end
        void'(pending_reads.pop_front());
      end
    end
  end

  // Receiver: random wait per transaction, long hold-off on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      while (hold_off) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // One input transaction, driven at falling edges
  task automatic send_item(pda_pkg::opcode_e op, logic [7:0] maj, logic [7:0] mnr,
                           logic [5:0] row, logic [5:0] col, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    major_count_i <= maj;
    minor_count_i <= mnr;
    row_sample_i <= row;
    col_sample_i <= col;
    do @(posedge clk_i); while (in_stall_o);
    predict_sums(op, maj, mnr, row, col);
    @(negedge clk_i);
  endtask

  // Idle the block, then write the sample count
  task automatic set_samples(logic [6:0] val);
    in_valid_i <= 1'b0;
    while (pending_reads.size() != 0) @(negedge clk_i);
    repeat (4500) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    samples_cfg = val;
  endtask

  typedef struct {
    pda_pkg::opcode_e op;
    logic [7:0]  maj;
    logic [7:0]  mnr;
    logic [5:0]  row;
    logic [5:0]  col;
    bit          known;
    pair_sums_t  res;
  } stim_row_t;

  stim_row_t directed [$];

  // Add a random sample, most with coverage, some empty
  task automatic rand_add(bit no_gap);
    logic [7:0] a;
    logic [7:0] b;
    a = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    b = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      a = 8'($urandom_range(0, 2));
      b = 8'($urandom_range(0, 1));
    end
    send_item(pda_pkg::OP_ADD, a, b, 6'($urandom), 6'($urandom), no_gap);
  endtask

  task automatic rand_read(bit no_gap);
    int unsigned lim;
    lim = (samples_cfg == 0) ? 1 : (samples_cfg > NSAMP) ? NSAMP : samples_cfg;
    if ($urandom_range(0, 3) == 0)
      send_item(pda_pkg::OP_READ, 8'($urandom), 8'($urandom), 6'($urandom), 6'($urandom),
                no_gap);
    else
      send_item(pda_pkg::OP_READ, 8'($urandom), 8'($urandom),
                6'($urandom_range(0, lim - 1)), 6'($urandom_range(0, lim - 1)), no_gap);
  endtask

  // Random phase: mostly loci with reads between, rare clears and no-ops
  task automatic rand_phase(int items);
    int k;
    int sel;
    k = 0;
    while (k < items) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) rand_add(0);
      else if (sel < 96) rand_read(0);
      else if (sel < 98)
        send_item(pda_pkg::OP_CLEAR, 8'($urandom), 8'($urandom), 6'($urandom),
                  6'($urandom), 0);
      else send_item(pda_pkg::OP_NONE, 8'($urandom), 8'($urandom), 6'($urandom),
                     6'($urandom), 0);
      k++;
    end
  endtask

  initial begin
    for (int k = 0; k < NSAMP; k++) begin
      buf_maj[k] = '0;
      buf_min[k] = '0;
    end
    clear_sums();
    samples_cfg = 7'd64;
    locus_pos = 0;

    // Directed table: known answers typed in where obvious
    directed = '{
      '{pda_pkg::OP_READ, 8'd0, 8'd0, 6'd0, 6'd0, 1, '{64'd0, 64'd0, 1'b1}},
      '{pda_pkg::OP_READ, 8'd0, 8'd0, 6'd63, 6'd0, 1, '{64'd0, 64'd0, 1'b1}},
      '{pda_pkg::OP_ADD, 8'd255, 8'd255, 6'd0, 6'd0, 0, '0},
      '{pda_pkg::OP_READ, 8'd0, 8'd0, 6'd0, 6'd0, 1, '{64'd259590, 64'd130050, 1'b0}},
      '{pda_pkg::OP_ADD, 8'd0, 8'd0, 6'd0, 6'd0, 0, '0},
      '{pda_pkg::OP_ADD, 8'd1, 8'd0, 6'd0, 6'd0, 0, '0},
      '{pda_pkg::OP_ADD, 8'd255, 8'd0, 6'd0, 6'd0, 0, '0},
      '{pda_pkg::OP_ADD, 8'd0, 8'd255, 6'd0, 6'd0, 0, '0},
      '{pda_pkg::OP_READ, 8'd0, 8'd0, 6'd1, 6'd0, 1, '{64'd0, 64'd0, 1'b1}},
      '{pda_pkg::OP_READ, 8'd0, 8'd0, 6'd2, 6'd2, 1, '{64'd0, 64'd0, 1'b1}},
      '{pda_pkg::OP_READ, 8'd0, 8'd0, 6'd0, 6'd2, 0, '0},
      '{pda_pkg::OP_READ, 8'd0, 8'd0, 6'd2, 6'd0, 0, '0},
      '{pda_pkg::OP_READ, 8'd0, 8'd0, 6'd4, 6'd3, 0, '0},
      '{pda_pkg::OP_NONE, 8'd255, 8'd255, 6'd63, 6'd63, 0, '0},
      '{pda_pkg::OP_CLEAR, 8'd0, 8'd0, 6'd0, 6'd0, 0, '0},
      '{pda_pkg::OP_READ, 8'd0, 8'd0, 6'd0, 6'd0, 1, '{64'd0, 64'd0, 1'b1}},
      '{pda_pkg::OP_ADD, 8'd3, 8'd2, 6'd0, 6'd0, 0, '0},
      '{pda_pkg::OP_READ, 8'd255, 8'd255, 6'd5, 6'd5, 1, '{64'd20, 64'd12, 1'b0}}
    };

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[k]) begin
      send_item(directed[k].op, directed[k].maj, directed[k].mnr, directed[k].row,
                directed[k].col, 0);
      if (directed[k].known && pending_reads[$] !== directed[k].res) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: exp w=%h d=%h nd=%b got w=%h d=%h nd=%b", k,
                   directed[k].res.weight, directed[k].res.div, directed[k].res.empty,
                   pending_reads[$].weight, pending_reads[$].div, pending_reads[$].empty);
      end
    end

    // Settings: extremes, small loci, out-of-range codes, lowering mid-locus
    set_samples(7'd1);
    rand_phase(150);
    set_samples(7'd2);
    rand_phase(200);
    set_samples(7'd0);
    rand_phase(60);
    set_samples(7'd5);
    rand_phase(300);
    set_samples(7'd3);
    rand_phase(150);
    set_samples(7'd127);
    rand_phase(250);
    set_samples(7'd64);
    // Full locus of 64, then 40 random reads with a long receiver hold-off
    for (int k = 0; k < 64; k++) rand_add(1);
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 40; k++) rand_read(1);
    join
    rand_phase(300);
    set_samples(7'd8);
    rand_phase(RAND_ITEMS - 1532);

    in_valid_i <= 1'b0;
    while (pending_reads.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
